// ----- rtl/core/gn3_pkg.sv -----
package gn3_pkg;

   // Operation carried by each request transfer.
   typedef enum logic [0:0] {
      OP_EVALUATE = 1'b0,
      OP_LOAD     = 1'b1
   } operation_type;

   // Fixed field widths of the channels.
   localparam int COORD_WIDTH = 32;
   localparam int ENTRY_WIDTH = 8;
   localparam int NOISE_WIDTH = 18;
   localparam int TABLE_DEPTH = 256;

   // Saturation limits of the result.
   localparam int NOISE_MAX = 131071;
   localparam int NOISE_MIN = -131072;

endpackage

// ----- rtl/core/gn3_req_if.sv -----
interface gn3_req_if;
   logic                                     valid;
   logic                                     ready;
   gn3_pkg::operation_type                   operation;
   logic signed [gn3_pkg::COORD_WIDTH-1:0]   coord_x;
   logic signed [gn3_pkg::COORD_WIDTH-1:0]   coord_y;
   logic signed [gn3_pkg::COORD_WIDTH-1:0]   coord_z;
   logic        [gn3_pkg::ENTRY_WIDTH-1:0]   entry_index;
   logic        [gn3_pkg::ENTRY_WIDTH-1:0]   entry_value;

   modport source (output valid, output operation, output coord_x, output coord_y,
                   output coord_z, output entry_index, output entry_value, input ready);
   modport sink   (input valid, input operation, input coord_x, input coord_y,
                   input coord_z, input entry_index, input entry_value, output ready);
endinterface

// ----- rtl/core/gn3_rsp_if.sv -----
interface gn3_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [gn3_pkg::NOISE_WIDTH-1:0]   noise_value;

   modport source (output valid, output noise_value, input ready);
   modport sink   (input valid, input noise_value, output ready);
endinterface

// ----- rtl/core/gradient_noise_3d_evaluator.sv -----
// A request passes through ten pipeline stages (stages 0 to 9) and then the output register.
// Throughput: one request per cycle unless stalled; a load takes one slot and gives no result.
// The whole pipeline, including the table read ports, holds while a result waits.
// Reset clears all valid bits and starts a pass that writes the identity permutation
// into all 256 entries of every table copy; requests are held off until that pass ends.
module gradient_noise_3d_evaluator #(
   parameter int FRACTION_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   gn3_req_if.sink    req_port,
   gn3_rsp_if.source  rsp_port
);

   localparam int FW  = FRACTION_BITS;
   localparam int GW  = FW + 3;          // gradient and blend values
   localparam int DW  = GW + 1;          // blend difference
   localparam int UW  = FW + 2;          // signed fade weight
   localparam int PW  = DW + UW;         // blend product
   localparam int QW  = FW + 5;          // fade polynomial
   localparam int SQW = 2 * FW + 1;      // square and cube products
   localparam int FDW = 2 * FW + 5;      // fade product
   localparam int EW  = gn3_pkg::ENTRY_WIDTH;
   localparam int TD  = gn3_pkg::TABLE_DEPTH;
   localparam int NW  = gn3_pkg::NOISE_WIDTH;

   localparam logic [SQW-1:0]       HALF_SQ = SQW'(64'd1 << (FW - 1));
   localparam logic [FDW-1:0]       HALF_FD = FDW'(64'd1 << (FW - 1));
   localparam logic signed [PW-1:0] HALF_P  = PW'(64'd1 << (FW - 1));
   localparam logic [QW-1:0]        TEN_ONE = QW'(64'd10 << FW);
   localparam logic [QW-1:0]        SIX     = QW'(6);
   localparam logic [QW-1:0]        FIFTEEN = QW'(15);
   localparam logic [QW-1:0]        ONE_Q   = QW'(64'd1 << FW);
   localparam logic signed [GW-1:0] ONE_G   = GW'(64'd1 << FW);
   localparam logic [3:0]           GRAD_U_LIMIT = 4'd8;
   localparam logic [3:0]           GRAD_V_LIMIT = 4'd4;
   localparam logic [3:0]           GRAD_SWAP_A  = 4'd12;
   localparam logic [3:0]           GRAD_SWAP_B  = 4'd14;
   localparam logic signed [31:0]   SAT_MAX = 32'(gn3_pkg::NOISE_MAX);
   localparam logic signed [31:0]   SAT_MIN = 32'(gn3_pkg::NOISE_MIN);

   // Gradient dot product for one corner.
   function automatic logic signed [GW-1:0] grad(input logic [EW-1:0] hash,
         input logic signed [GW-1:0] x, input logic signed [GW-1:0] y,
         input logic signed [GW-1:0] z);
      logic [3:0]             h;
      logic signed [GW-1:0]   gu;
      logic signed [GW-1:0]   gv;
      h  = hash[3:0];
      gu = (h < GRAD_U_LIMIT) ? x : y;
      if (h < GRAD_V_LIMIT) begin
         gv = y;
      end else if (h == GRAD_SWAP_A || h == GRAD_SWAP_B) begin
         gv = x;
      end else begin
         gv = z;
      end
      if (h[0]) begin
         gu = -gu;
      end
      if (h[1]) begin
         gv = -gv;
      end
      return gu + gv;
   endfunction

   // First half of a blend: weight times the difference.
   function automatic logic signed [PW-1:0] blend_mul(input logic [FW:0] t,
         input logic signed [GW-1:0] a, input logic signed [GW-1:0] b);
      logic signed [DW-1:0] d;
      logic signed [UW-1:0] ts;
      d  = DW'(b) - DW'(a);
      ts = signed'(UW'(t));
      return d * ts;
   endfunction

   // Second half of a blend: round the product and add the start value.
   function automatic logic signed [GW-1:0] blend_add(input logic signed [GW-1:0] a,
         input logic signed [PW-1:0] p);
      logic signed [PW-1:0] s;
      s = (p + HALF_P) >>> FW;
      return signed'(GW'(a + s[GW-1:0]));
   endfunction

   // Global stall: every stage moves when the output register can take a result.
   logic rsp_valid_ff;
   logic clear_ff;
   logic [EW-1:0] clear_index_ff;
   logic advance;
   assign advance        = !rsp_valid_ff || rsp_port.ready;
   assign req_port.ready = advance && !clear_ff;

   // Stage registers.
   logic                   s0_valid_ff, s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic                   s5_valid_ff, s6_valid_ff, s7_valid_ff, s8_valid_ff, s9_valid_ff;
   gn3_pkg::operation_type s0_op_ff, s1_op_ff, s2_op_ff;
   logic [EW-1:0]          s0_cell_ff [3];
   logic [EW-1:0]          s1_cell_ff [3];
   logic [EW-1:0]          s2_cell_z_ff;
   logic [FW-1:0]          s0_frac_ff [3];
   logic [FW-1:0]          s1_frac_ff [3];
   logic [FW-1:0]          s2_frac_ff [3];
   logic [FW-1:0]          s3_frac_ff [3];
   logic [EW-1:0]          s0_index_ff, s1_index_ff, s2_index_ff;
   logic [EW-1:0]          s0_value_ff, s1_value_ff, s2_value_ff;
   logic [FW:0]            s2_t2_ff [3];
   logic [FW:0]            s3_t3_ff [3];
   logic [FW+3:0]          s3_q_ff [3];
   logic [FW:0]            s4_fade_ff [3];
   logic [FW:0]            s5_fade_ff [3];
   logic [FW:0]            s6_fade_ff [3];
   logic [FW:0]            s7_fade_ff [3];
   logic [FW:0]            s8_fade_ff [3];
   logic [EW-1:0]          s2_a_ff, s2_b_ff;
   logic [EW-1:0]          s3_base_ff [4];
   logic signed [GW-1:0]   s4_grad_ff [8];
   logic signed [PW-1:0]   s5_prod_ff [4];
   logic signed [GW-1:0]   s5_start_ff [4];
   logic signed [GW-1:0]   s6_lx_ff [4];
   logic signed [PW-1:0]   s7_prod_ff [2];
   logic signed [GW-1:0]   s7_start_ff [2];
   logic signed [GW-1:0]   s8_ly_ff [2];
   logic signed [PW-1:0]   s9_prod_ff;
   logic signed [GW-1:0]   s9_start_ff;
   logic signed [NW-1:0]   rsp_noise_ff;

   // Table copies: one per pair of read ports, each written as a load passes its level.
   logic [EW-1:0]   table1_mem [TD];
   logic [EW-1:0]   table2_mem [2][TD];
   logic [EW-1:0]   table3_mem [4][TD];
   logic [EW-1:0]   rd1_data_ff [2];
   logic [EW-1:0]   rd2_data_ff [4];
   logic [EW-1:0]   rd3_data_ff [8];

   // Combinational stage values.
   logic [SQW-1:0]         sq_w [3];
   logic [FW:0]            t2_in [3];
   logic [SQW-1:0]         cube_w [3];
   logic [QW-1:0]          q_w [3];
   logic [FDW-1:0]         fd_w [3];
   logic [FW+4:0]          fd_r [3];
   logic [FW:0]            fade_in [3];
   logic [EW-1:0]          perm_x, perm_x1, a_in, b_in;
   logic [EW-1:0]          perm2 [4];
   logic [EW-1:0]          base_in [4];
   logic [EW-1:0]          hash3 [8];
   logic signed [GW-1:0]   px [3];
   logic signed [GW-1:0]   px1 [3];
   logic signed [31:0]     result_w;
   logic signed [NW-1:0]   result_sat;
   logic                   load1, load2, load3;

   assign load1 = s0_valid_ff && (s0_op_ff == gn3_pkg::OP_LOAD);
   assign load2 = s1_valid_ff && (s1_op_ff == gn3_pkg::OP_LOAD);
   assign load3 = s2_valid_ff && (s2_op_ff == gn3_pkg::OP_LOAD);

   // Fade polynomial, split over the first stages.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sq_w[k]   = SQW'(s1_frac_ff[k]) * SQW'(s1_frac_ff[k]) + HALF_SQ;
         t2_in[k]  = sq_w[k][2*FW:FW];
         cube_w[k] = SQW'(s2_t2_ff[k]) * SQW'(s2_frac_ff[k]) + HALF_SQ;
         q_w[k]    = QW'(s2_t2_ff[k]) * SIX + TEN_ONE - QW'(s2_frac_ff[k]) * FIFTEEN;
         fd_w[k]   = FDW'(s3_t3_ff[k]) * FDW'(s3_q_ff[k]) + HALF_FD;
         fd_r[k]   = fd_w[k][FDW-1:FW];
         fade_in[k] = (QW'(fd_r[k]) > ONE_Q) ? ONE_Q[FW:0] : fd_r[k][FW:0];
      end
   end

   // Hash chain through the three table levels.
   always_comb begin
      perm_x  = rd1_data_ff[0];
      perm_x1 = rd1_data_ff[1];
      a_in    = EW'(perm_x + s1_cell_ff[1]);
      b_in    = EW'(perm_x1 + s1_cell_ff[1]);
      perm2[0] = rd2_data_ff[0];
      perm2[1] = rd2_data_ff[1];
      perm2[2] = rd2_data_ff[2];
      perm2[3] = rd2_data_ff[3];
      // Corner order: AA, BA, AB, BB.
      base_in[0] = EW'(perm2[0] + s2_cell_z_ff);
      base_in[1] = EW'(perm2[2] + s2_cell_z_ff);
      base_in[2] = EW'(perm2[1] + s2_cell_z_ff);
      base_in[3] = EW'(perm2[3] + s2_cell_z_ff);
      for (int c = 0; c < 4; c++) begin
         hash3[c]     = rd3_data_ff[2*c];
         hash3[c + 4] = rd3_data_ff[2*c+1];
      end
      for (int k = 0; k < 3; k++) begin
         px[k]  = signed'(GW'(s3_frac_ff[k]));
         px1[k] = px[k] - ONE_G;
      end
   end

   // Final blend, rounding and saturation.
   always_comb begin
      result_w = 32'(blend_add(s9_start_ff, s9_prod_ff));
      if (result_w > SAT_MAX) begin
         result_sat = NW'(SAT_MAX);
      end else if (result_w < SAT_MIN) begin
         result_sat = NW'(SAT_MIN);
      end else begin
         result_sat = result_w[NW-1:0];
      end
   end

   // Clearing pass after reset: one table entry per cycle in every copy.
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff       <= 1'b1;
         clear_index_ff <= '0;
      end else if (clear_ff) begin
         clear_index_ff <= EW'(clear_index_ff + 1'b1);
         if (clear_index_ff == EW'(TD - 1)) begin
            clear_ff <= 1'b0;
         end
      end
   end

   // Valid bits of the stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         s8_valid_ff  <= 1'b0;
         s9_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff  <= req_port.valid && !clear_ff;
         s1_valid_ff  <= s0_valid_ff;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff && (s2_op_ff == gn3_pkg::OP_EVALUATE);
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= s5_valid_ff;
         s7_valid_ff  <= s6_valid_ff;
         s8_valid_ff  <= s7_valid_ff;
         s9_valid_ff  <= s8_valid_ff;
         rsp_valid_ff <= s9_valid_ff;
      end
   end

   // Table copies: identity during the clearing pass, then write at the level of the
   // load; registered reads.
   always_ff @(posedge clock) begin
      if (clear_ff) begin
         table1_mem[clear_index_ff] <= clear_index_ff;
         for (int k = 0; k < 2; k++) begin
            table2_mem[k][clear_index_ff] <= clear_index_ff;
         end
         for (int k = 0; k < 4; k++) begin
            table3_mem[k][clear_index_ff] <= clear_index_ff;
         end
      end else if (advance) begin
         if (load1) begin
            table1_mem[s0_index_ff] <= s0_value_ff;
         end
         if (load2) begin
            for (int k = 0; k < 2; k++) begin
               table2_mem[k][s1_index_ff] <= s1_value_ff;
            end
         end
         if (load3) begin
            for (int k = 0; k < 4; k++) begin
               table3_mem[k][s2_index_ff] <= s2_value_ff;
            end
         end
      end
      if (advance) begin
         rd1_data_ff[0] <= table1_mem[s0_cell_ff[0]];
         rd1_data_ff[1] <= table1_mem[EW'(s0_cell_ff[0] + 1'b1)];
         rd2_data_ff[0] <= table2_mem[0][a_in];
         rd2_data_ff[1] <= table2_mem[0][EW'(a_in + 1'b1)];
         rd2_data_ff[2] <= table2_mem[1][b_in];
         rd2_data_ff[3] <= table2_mem[1][EW'(b_in + 1'b1)];
         for (int c = 0; c < 4; c++) begin
            rd3_data_ff[2*c]   <= table3_mem[c][base_in[c]];
            rd3_data_ff[2*c+1] <= table3_mem[c][EW'(base_in[c] + 1'b1)];
         end
      end
   end

   // Pipeline payload.
   always_ff @(posedge clock) begin
      if (advance) begin
         // Stage 0: split the coordinates into cell and fraction.
         s0_op_ff      <= req_port.operation;
         s0_cell_ff[0] <= req_port.coord_x[FW +: EW];
         s0_cell_ff[1] <= req_port.coord_y[FW +: EW];
         s0_cell_ff[2] <= req_port.coord_z[FW +: EW];
         s0_frac_ff[0] <= req_port.coord_x[FW-1:0];
         s0_frac_ff[1] <= req_port.coord_y[FW-1:0];
         s0_frac_ff[2] <= req_port.coord_z[FW-1:0];
         s0_index_ff   <= req_port.entry_index;
         s0_value_ff   <= req_port.entry_value;

         // Stage 1: first hash level, fade square.
         s1_op_ff    <= s0_op_ff;
         s1_cell_ff  <= s0_cell_ff;
         s1_frac_ff  <= s0_frac_ff;
         s1_index_ff <= s0_index_ff;
         s1_value_ff <= s0_value_ff;

         // Stage 2: second hash level, fade cube and polynomial.
         s2_op_ff     <= s1_op_ff;
         s2_cell_z_ff <= s1_cell_ff[2];
         s2_frac_ff   <= s1_frac_ff;
         s2_index_ff  <= s1_index_ff;
         s2_value_ff  <= s1_value_ff;
         s2_t2_ff     <= t2_in;
         s2_a_ff      <= a_in;
         s2_b_ff      <= b_in;

         // Stage 3: corner hashes, fade product.
         s3_frac_ff <= s2_frac_ff;
         s3_base_ff <= base_in;
         for (int k = 0; k < 3; k++) begin
            s3_t3_ff[k] <= cube_w[k][2*FW:FW];
            s3_q_ff[k]  <= q_w[k][FW+3:0];
         end

         // Stage 4: gradients of the eight corners.
         s4_fade_ff <= fade_in;
         for (int c = 0; c < 8; c++) begin
            s4_grad_ff[c] <= grad(hash3[c], c[0] ? px1[0] : px[0],
                                  c[1] ? px1[1] : px[1], c[2] ? px1[2] : px[2]);
         end

         // Stages 5 and 6: blend along x.
         s5_fade_ff <= s4_fade_ff;
         for (int i = 0; i < 4; i++) begin
            s5_prod_ff[i]  <= blend_mul(s4_fade_ff[0], s4_grad_ff[2*i], s4_grad_ff[2*i+1]);
            s5_start_ff[i] <= s4_grad_ff[2*i];
         end
         s6_fade_ff <= s5_fade_ff;
         for (int i = 0; i < 4; i++) begin
            s6_lx_ff[i] <= blend_add(s5_start_ff[i], s5_prod_ff[i]);
         end

         // Stages 7 and 8: blend along y.
         s7_fade_ff <= s6_fade_ff;
         for (int j = 0; j < 2; j++) begin
            s7_prod_ff[j]  <= blend_mul(s6_fade_ff[1], s6_lx_ff[2*j], s6_lx_ff[2*j+1]);
            s7_start_ff[j] <= s6_lx_ff[2*j];
         end
         s8_fade_ff <= s7_fade_ff;
         for (int j = 0; j < 2; j++) begin
            s8_ly_ff[j] <= blend_add(s7_start_ff[j], s7_prod_ff[j]);
         end

         // Stage 9 and output: blend along z, then saturate.
         s9_prod_ff   <= blend_mul(s8_fade_ff[2], s8_ly_ff[0], s8_ly_ff[1]);
         s9_start_ff  <= s8_ly_ff[0];
         rsp_noise_ff <= result_sat;
      end
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.noise_value = rsp_noise_ff;

endmodule
